// ===== rtl/sfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and the byte-wise CRC-16/CCITT-FALSE update for
// the sync frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned FrameLen = 10;
  localparam int unsigned CrcSpan  = 8;
  localparam int unsigned PosW     = 4;

  localparam logic [7:0]  SyncFirst    = 8'hA5;
  localparam logic [7:0]  SyncSecond   = 8'h5A;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] TimeoutReset = 16'd1000;
  localparam logic [15:0] IdleMax      = 16'hFFFF;

  localparam logic [PosW-1:0] PosFirst  = PosW'(0);
  localparam logic [PosW-1:0] PosSecond = PosW'(1);
  localparam logic [PosW-1:0] PosCrcLow = PosW'(CrcSpan);
  localparam logic [PosW-1:0] PosLast   = PosW'(FrameLen - 1);

  typedef logic [PosW-1:0] pos_t;
  typedef logic [7:0]      byte_t;

  // One byte of CRC-16/CCITT-FALSE (poly 0x1021, MSB first), table-free form.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input byte_t b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ {4'b0000, x[7:4]};
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
           ^ {8'h00, x};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sync_frame_receiver_crc16.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sync_frame_receiver_crc16
// Deframer for 10-byte sync frames with CRC-16/CCITT-FALSE check and a
// tick-based idle timeout.
// ----------------------------------------------------------------------------
// The block accepts one input beat per clock cycle, sustained, as long as the
// result side keeps up. A beat is either a received byte (tuser = 0) or one
// timer tick (tuser = 1). Each beat is first captured in an input register;
// then, once the result register is free, the frame state (position,
// running CRC, payload bytes and idle counter) is updated by a single
// byte-wide CRC step and one 16-bit compare, and a completed frame is
// written into the result register. Because the result register frees up
// in the same cycle its beat is taken, back-to-back frames and tick beats
// never stall the input unless the result side holds tready low. Frames
// start with the pair 0xA5 0x5A; bytes 8 and 9 carry the expected CRC over
// bytes 0..7, low byte first. A result beat reports crc_ok in tuser and the
// three little-endian words in tdata whether or not the CRC matched. Every
// byte but the one that closes a frame restarts the idle timeout; after
// timeout_ticks further ticks with no byte, a partial frame is dropped. The
// timeout register may be written only while the block is idle.
// ----------------------------------------------------------------------------
module sync_frame_receiver_crc16 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // Timeout register write port.
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,

  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] mode (1 = timer tick)

  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [15:0] command, [31:16] data_first,
                                           // [47:32] data_second
  output logic             m_axis_tuser    // [0] crc_ok
);

  // Timeout register.
  logic [15:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= sfr_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // Input register stage.
  logic          in_valid_q;
  logic          in_mode_q;
  sfr_pkg::byte_t in_byte_q;
  logic          advance;
  logic          out_free;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  // Frame state.
  sfr_pkg::pos_t  pos_q, pos_d;
  logic [15:0]    crc_q, crc_d;
  logic           timer_q, timer_d;
  logic [15:0]    idle_q, idle_d;
  sfr_pkg::byte_t payload_q [sfr_pkg::CrcSpan];
  sfr_pkg::byte_t crc_low_q;

  // Byte store controls.
  logic           take;       // byte joins the frame at position take_pos
  sfr_pkg::pos_t  take_pos;
  logic [15:0]    take_crc;   // CRC before this byte is folded in
  logic           emit;
  logic           crc_match;
  logic [15:0]    idle_inc;

  assign idle_inc  = (idle_q == sfr_pkg::IdleMax) ? idle_q : idle_q + 16'd1;
  assign crc_match = (crc_q == {in_byte_q, crc_low_q});

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    timer_d  = timer_q;
    idle_d   = idle_q;
    take     = 1'b0;
    take_pos = pos_q;
    take_crc = crc_q;
    emit     = 1'b0;

    if (in_mode_q) begin
      // Timer tick: count idle time and drop a stale partial frame.
      if (timer_q) begin
        idle_d = idle_inc;
        if (idle_inc >= timeout_q) begin
          pos_d   = sfr_pkg::PosFirst;
          crc_d   = sfr_pkg::CrcInit;
          timer_d = 1'b0;
        end
      end
    end else begin
      timer_d = 1'b1;
      idle_d  = '0;
      if (pos_q == sfr_pkg::PosFirst) begin
        crc_d = sfr_pkg::CrcInit;
        if (in_byte_q == sfr_pkg::SyncFirst) begin
          take     = 1'b1;
          take_crc = sfr_pkg::CrcInit;
        end
      end else if (pos_q == sfr_pkg::PosSecond) begin
        if (in_byte_q != sfr_pkg::SyncSecond) begin
          // A false second byte may itself open a new frame.
          pos_d = sfr_pkg::PosFirst;
          crc_d = sfr_pkg::CrcInit;
          if (in_byte_q == sfr_pkg::SyncFirst) begin
            take     = 1'b1;
            take_pos = sfr_pkg::PosFirst;
            take_crc = sfr_pkg::CrcInit;
          end
        end else begin
          take = 1'b1;
        end
      end else if (pos_q >= sfr_pkg::PosLast) begin
        emit    = 1'b1;
        pos_d   = sfr_pkg::PosFirst;
        crc_d   = sfr_pkg::CrcInit;
        timer_d = 1'b0;
      end else begin
        take = 1'b1;
      end

      if (take) begin
        pos_d = take_pos + sfr_pkg::pos_t'(1);
        if (take_pos < sfr_pkg::PosCrcLow) begin
          crc_d = sfr_pkg::crc_feed(take_crc, in_byte_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= sfr_pkg::PosFirst;
      crc_q   <= sfr_pkg::CrcInit;
      timer_q <= 1'b0;
      idle_q  <= '0;
    end else if (advance) begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      timer_q <= timer_d;
      idle_q  <= idle_d;
    end
  end

  // Payload bytes: written by position, read at fixed places.
  always_ff @(posedge clk_i) begin
    if (advance && take) begin
      if (take_pos < sfr_pkg::PosCrcLow) begin
        payload_q[take_pos[2:0]] <= in_byte_q;
      end else begin
        crc_low_q <= in_byte_q;
      end
    end
  end

  // Result register.
  logic        out_valid_q;
  logic        out_ok_q;
  logic [47:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_ok_q   <= crc_match;
      out_data_q <= {payload_q[7], payload_q[6], payload_q[5], payload_q[4],
                     payload_q[3], payload_q[2]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = out_data_q;

  // Checks.
  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= sfr_pkg::PosLast)
    else $error("frame position beyond last byte");

  a_idle_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !timer_q |-> (pos_q == sfr_pkg::PosFirst && crc_q == sfr_pkg::CrcInit))
    else $error("partial frame held with the timeout stopped");

  a_emit_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (pos_q == sfr_pkg::PosFirst && !timer_q && m_axis_tvalid))
    else $error("completed frame did not restart the receiver");

endmodule
`default_nettype wire

// ===== test/tb_sync_frame_receiver_crc16.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_frame_receiver_crc16
// Self-checking bench for the sync frame receiver. A queue of byte and tick
// beats feeds a bursty stream driver. A frame tracker follows every accepted
// beat and predicts each decoded frame. A monitor compares result beats
// against those predictions while the result side stalls on a changing
// pattern. The timeout register is stepped through several values,
// including its extremes.
// ----------------------------------------------------------------------------
module tb_sync_frame_receiver_crc16;

  // Cycles of quiet after the last result before the block counts as idle.
  // Tick beats produce no result.
  localparam int DrainCycles   = 6;
  // Cycles with no beat moving on either side before the run is declared hung.
  localparam int WatchdogLimit = 5000;
  // Error lines beyond this count are still counted but not printed.
  localparam int MaxErrorLines = 40;

  typedef struct packed {
    logic           tick;  // 1 = timer tick, 0 = received byte
    sfr_pkg::byte_t rx;
  } link_beat_t;

  typedef struct packed {
    logic        crc_ok;
    logic [15:0] command;
    logic [15:0] data_first;
    logic [15:0] data_second;
  } frame_fields_t;

  // DUT ports. Every input starts at a known value.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = 16'h0000;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  sync_frame_receiver_crc16 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Beats waiting to be driven and frames waiting to come out.
  link_beat_t    link_beats[$];
  frame_fields_t frames_due[$];
  int            beats_queued = 0;
  int            error_count  = 0;

  // --------------------------------------------------------------------------
  // Frame tracker state. It mirrors the deframer: position inside the frame,
  // captured payload, running CRC, the held CRC low byte and the idle timer.
  // tmo_limit is the bench's copy of the timeout register.
  // --------------------------------------------------------------------------
  logic [15:0]    tmo_limit   = sfr_pkg::TimeoutReset;
  sfr_pkg::pos_t  frame_pos   = sfr_pkg::PosFirst;
  sfr_pkg::byte_t frame_bytes [sfr_pkg::CrcSpan] = '{default: 8'h00};
  logic [15:0]    frame_crc   = sfr_pkg::CrcInit;
  sfr_pkg::byte_t crc_lo      = 8'h00;
  logic           tmo_armed   = 1'b0;
  logic [15:0]    tmo_count   = 16'h0000;

  // CRC-16/CCITT-FALSE, one byte at a time, shifted out bit by bit.
  function automatic logic [15:0] ccitt_step(logic [15:0] crc, sfr_pkg::byte_t b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  // Stores a frame byte: bytes 0..7 feed the CRC, byte 8 is held as the
  // low half of the received CRC.
  task automatic store_frame_byte(sfr_pkg::byte_t b);
    if (frame_pos < sfr_pkg::PosCrcLow) begin
      frame_bytes[frame_pos[2:0]] = b;
      frame_crc = ccitt_step(frame_crc, b);
    end else begin
      crc_lo = b;
    end
    frame_pos = frame_pos + 1'b1;
  endtask

  // Advances the tracker by one accepted input beat and queues the decoded
  // frame when the beat closes one.
  task automatic track_frame(logic tick, sfr_pkg::byte_t b);
    frame_fields_t done;
    if (tick) begin
      // Ticks only matter while a byte has armed the timer.
      if (tmo_armed) begin
        if (tmo_count != sfr_pkg::IdleMax) tmo_count = tmo_count + 1'b1;
        if (tmo_count >= tmo_limit) begin
          frame_pos = sfr_pkg::PosFirst;
          frame_crc = sfr_pkg::CrcInit;
          tmo_armed = 1'b0;
        end
      end
    end else begin
      // Any byte restarts the idle timer, even one dropped while hunting; a closing byte then stops it.
      tmo_armed = 1'b1;
      tmo_count = 16'h0000;
      if (frame_pos == sfr_pkg::PosFirst) begin
        frame_crc = sfr_pkg::CrcInit;
        if (b == sfr_pkg::SyncFirst) store_frame_byte(b);
      end else if (frame_pos == sfr_pkg::PosSecond) begin
        if (b != sfr_pkg::SyncSecond) begin
          // A wrong second byte drops the pair, but a fresh first sync byte
          // starts over right away.
          frame_pos = sfr_pkg::PosFirst;
          frame_crc = sfr_pkg::CrcInit;
          if (b == sfr_pkg::SyncFirst) store_frame_byte(b);
        end else begin
          store_frame_byte(b);
        end
      end else if (frame_pos >= sfr_pkg::PosLast) begin
        done.crc_ok      = (frame_crc == {b, crc_lo});
        done.command     = {frame_bytes[3], frame_bytes[2]};
        done.data_first  = {frame_bytes[5], frame_bytes[4]};
        done.data_second = {frame_bytes[7], frame_bytes[6]};
        frames_due.push_back(done);
        frame_pos = sfr_pkg::PosFirst;
        frame_crc = sfr_pkg::CrcInit;
        tmo_armed = 1'b0;
      end else begin
        store_frame_byte(b);
      end
    end
  endtask

  task automatic report_error(string msg);
    if (error_count < MaxErrorLines) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers. They only fill link_beats; the driver takes care of
  // timing.
  // --------------------------------------------------------------------------
  task automatic push_beat(logic tick, sfr_pkg::byte_t b);
    link_beat_t nb;
    nb.tick = tick;
    nb.rx   = b;
    link_beats.push_back(nb);
    beats_queued++;
  endtask

  // Tick beats carry a random byte so that tdata also toggles on them.
  task automatic push_ticks(int n);
    repeat (n) push_beat(1'b1, sfr_pkg::byte_t'($urandom));
  endtask

  // One complete frame. fill_kind selects the payload: 0 all zero, 1 all
  // ones, otherwise random. With tick_gaps set, short tick runs may fall
  // between bytes; at small timeouts they can kill the frame on purpose.
  task automatic push_frame(bit crc_good, int fill_kind, bit tick_gaps);
    sfr_pkg::byte_t wire_bytes [sfr_pkg::FrameLen];
    logic [15:0]    crc;
    crc = sfr_pkg::CrcInit;
    wire_bytes[0] = sfr_pkg::SyncFirst;
    wire_bytes[1] = sfr_pkg::SyncSecond;
    for (int k = 2; k < sfr_pkg::CrcSpan; k++) begin
      wire_bytes[k] = (fill_kind == 0) ? 8'h00 :
                      (fill_kind == 1) ? 8'hFF : sfr_pkg::byte_t'($urandom);
    end
    for (int k = 0; k < sfr_pkg::CrcSpan; k++) crc = ccitt_step(crc, wire_bytes[k]);
    if (!crc_good) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    wire_bytes[sfr_pkg::CrcSpan]     = crc[7:0];
    wire_bytes[sfr_pkg::CrcSpan + 1] = crc[15:8];
    for (int k = 0; k < sfr_pkg::FrameLen; k++) begin
      if (tick_gaps && k > 0 && $urandom_range(0, 99) < 8) push_ticks($urandom_range(1, 3));
      push_beat(1'b0, wire_bytes[k]);
    end
  endtask

  // Mostly well formed frames with random content, the rest stray bytes,
  // truncated frames left to time out, resync cases and lone tick runs.
  task automatic random_traffic(int n);
    int goal;
    int pick;
    int k;
    goal = beats_queued + n;
    while (beats_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        k = $urandom_range(0, 9);
        push_frame($urandom_range(0, 99) < 85, (k < 2) ? k : 2, 1'b1);
      end else if (pick < 80) begin
        // Stray bytes while hunting, biased toward the sync values.
        repeat ($urandom_range(1, 4)) begin
          k = $urandom_range(0, 3);
          push_beat(1'b0, (k == 0) ? sfr_pkg::SyncFirst :
                          (k == 1) ? sfr_pkg::SyncSecond : sfr_pkg::byte_t'($urandom));
        end
      end else if (pick < 90) begin
        // Truncated frame. When the timeout is short, follow it with ticks
        // that land either exactly on the limit or one short of it.
        push_beat(1'b0, sfr_pkg::SyncFirst);
        push_beat(1'b0, sfr_pkg::SyncSecond);
        repeat ($urandom_range(0, 7)) push_beat(1'b0, sfr_pkg::byte_t'($urandom));
        if (tmo_limit <= 40) begin
          k = (tmo_limit == 0) ? 1 : int'(tmo_limit) - $urandom_range(0, tmo_limit > 1);
          push_ticks(k);
        end
      end else if (pick < 95) begin
        // Doubled first sync byte: the receiver has to resync on the second.
        push_beat(1'b0, sfr_pkg::SyncFirst);
        push_frame(1'b1, 2, 1'b0);
      end else begin
        push_ticks($urandom_range(1, 5));
      end
    end
  endtask

  // Waits until every queued beat has been taken and every predicted frame
  // has come out, then lets the pipeline settle. Sampling on the falling
  // edge keeps this clear of the driver's updates.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (link_beats.size() != 0 || s_axis_tvalid || frames_due.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Register writes happen only while the block is idle, so the tracker's
  // copy can change at the same moment.
  task automatic write_timeout(logic [15:0] ticks);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    tmo_limit    = ticks;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Input driver. Beats go out in bursts of random length separated by
  // random gaps; a zero gap joins two bursts into one longer stretch. The
  // tracker sees each beat at the edge where it is accepted.
  // --------------------------------------------------------------------------
  int         burst_left = 1;
  int         gap_left   = 0;
  link_beat_t next_beat;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) track_frame(s_axis_tuser, s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (link_beats.size() != 0) begin
          next_beat = link_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= next_beat.tick;
          s_axis_tdata  <= next_beat.rx;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and receiver stall pattern. The pattern is a rotating
  // 32-bit word, reloaded with one of four kinds: all ready, random,
  // mostly ready or mostly stalled.
  // --------------------------------------------------------------------------
  logic [31:0]   ready_bits  = 32'hFFFF_FFFF;
  int            ready_phase = 0;
  frame_fields_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frames_due.size() == 0) begin
        report_error($sformatf("result beat with no frame pending: tuser=%b tdata=%h",
                               m_axis_tuser, m_axis_tdata));
      end else begin
        want = frames_due.pop_front();
        if (m_axis_tuser !== want.crc_ok)
          report_error($sformatf("crc_ok: got %b, want %b", m_axis_tuser, want.crc_ok));
        if (m_axis_tdata[15:0] !== want.command)
          report_error($sformatf("command: got %h, want %h", m_axis_tdata[15:0], want.command));
        if (m_axis_tdata[31:16] !== want.data_first)
          report_error($sformatf("data_first: got %h, want %h",
                                 m_axis_tdata[31:16], want.data_first));
        if (m_axis_tdata[47:32] !== want.data_second)
          report_error($sformatf("data_second: got %h, want %h",
                                 m_axis_tdata[47:32], want.data_second));
      end
    end
    ready_phase++;
    if (ready_phase % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          ready_bits = 32'hFFFF_FFFF;
        end
        1: begin
          ready_bits = $urandom;
        end
        2: begin
          ready_bits = $urandom | $urandom;
        end
        default: begin
          ready_bits = $urandom & $urandom;
        end
      endcase
    end
    m_axis_tready <= ready_bits[0];
    ready_bits = {ready_bits[0], ready_bits[31:1]};
  end

  // --------------------------------------------------------------------------
  // Watchdog: a run of cycles with no beat moving on either side means the
  // block has hung.
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, run at the reset timeout of the register.
    // A tick with the timer idle must do nothing.
    push_ticks(1);
    // Clean frame with an all-zero payload.
    push_frame(1'b1, 0, 1'b0);
    // First sync byte followed by a wrong second byte: dropped.
    push_beat(1'b0, sfr_pkg::SyncFirst);
    push_beat(1'b0, 8'h00);
    // Doubled first sync byte, then a frame with an all-ones payload.
    push_beat(1'b0, sfr_pkg::SyncFirst);
    push_frame(1'b1, 1, 1'b0);
    wait_drained();

    // Random part, stepping the timeout through its extremes and between.
    write_timeout(16'd1);
    random_traffic(150);
    wait_drained();

    // A zero timeout expires on the first tick, like a timeout of one.
    write_timeout(16'd0);
    random_traffic(100);
    wait_drained();

    write_timeout(16'hFFFF);
    random_traffic(200);
    wait_drained();

    write_timeout(16'($urandom_range(2, 12)));
    random_traffic(250);
    wait_drained();

    write_timeout(16'($urandom_range(13, 300)));
    random_traffic(200);
    wait_drained();

    write_timeout(sfr_pkg::TimeoutReset);
    random_traffic(100);
    wait_drained();

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
